/* rtl/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Sector codes and the per-pixel control word shared by the pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYAN = 3'd2,
    SEC_CYAN_BLU = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_e;

  typedef struct packed {
    logic    black;
    logic    grey;
    sector_e sector;
  } pix_ctrl_t;

endpackage

/* rtl/hsv2rgb_prep.sv */
// ----------------------------------------------------------------------------
// HSV to RGB front stage
// Clamps saturation and brightness, splits hue times six into sector and
// fraction, and flags the black and grey cases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv2rgb_prep #(
  parameter int FRAC_BITS = 15,
  parameter int HUE_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [HUE_BITS-1:0]      hue_i,
  input  logic [FRAC_BITS+1:0]     sat_i,
  input  logic [FRAC_BITS+1:0]     bright_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [FRAC_BITS:0]       sat_o,
  output logic [FRAC_BITS:0]       bright_o,
  output logic [FRAC_BITS-1:0]     frac_o,
  output hsv2rgb_pkg::pix_ctrl_t   ctrl_o
);
  import hsv2rgb_pkg::*;

  localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic [FRAC_BITS:0] clamp_level(input logic [FRAC_BITS+1:0] raw);
    logic [FRAC_BITS:0] res;
    if (raw[FRAC_BITS+1]) begin
      res = '0;
    end else if (raw[FRAC_BITS:0] > ONE_Q) begin
      res = ONE_Q;
    end else begin
      res = raw[FRAC_BITS:0];
    end
    return res;
  endfunction

  logic [HUE_BITS+2:0]  h6;
  logic [FRAC_BITS-1:0] frac;
  logic [FRAC_BITS:0]   sat_c, bright_c;
  pix_ctrl_t            ctrl_d;

  logic                 valid_q;
  logic [FRAC_BITS:0]   sat_q, bright_q;
  logic [FRAC_BITS-1:0] frac_q;
  pix_ctrl_t            ctrl_q;

  // hue * 6 = hue * 4 + hue * 2
  assign h6 = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};

  if (HUE_BITS >= FRAC_BITS) begin : g_frac_trunc
    assign frac = h6[HUE_BITS-1 -: FRAC_BITS];
  end else begin : g_frac_ext
    assign frac = {h6[HUE_BITS-1:0], {(FRAC_BITS-HUE_BITS){1'b0}}};
  end

  assign sat_c    = clamp_level(sat_i);
  assign bright_c = clamp_level(bright_i);

  always_comb begin
    ctrl_d.black  = (bright_c == '0);
    ctrl_d.grey   = (sat_c == '0);
    ctrl_d.sector = sector_e'(h6[HUE_BITS+2:HUE_BITS]);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sat_q    <= sat_c;
      bright_q <= bright_c;
      frac_q   <= frac;
      ctrl_q   <= ctrl_d;
    end
  end

  assign valid_o  = valid_q;
  assign sat_o    = sat_q;
  assign bright_o = bright_q;
  assign frac_o   = frac_q;
  assign ctrl_o   = ctrl_q;

endmodule

/* rtl/hsv2rgb_mul.sv */
// ----------------------------------------------------------------------------
// HSV to RGB product stages
// Two registered multiply stages forming the p, q and t terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv2rgb_mul #(
  parameter int FRAC_BITS = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [FRAC_BITS:0]       sat_i,
  input  logic [FRAC_BITS:0]       bright_i,
  input  logic [FRAC_BITS-1:0]     frac_i,
  input  hsv2rgb_pkg::pix_ctrl_t   ctrl_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [FRAC_BITS:0]       bright_o,
  output logic [FRAC_BITS:0]       p_o,
  output logic [FRAC_BITS:0]       q_o,
  output logic [FRAC_BITS:0]       t_o,
  output hsv2rgb_pkg::pix_ctrl_t   ctrl_o
);
  import hsv2rgb_pkg::*;

  localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int PROD_W = 2 * FRAC_BITS + 2;

  // first multiply stage
  logic [FRAC_BITS:0]     one_minus_s, one_minus_f;
  logic [PROD_W-1:0]      p_prod;
  logic [PROD_W-1:0]      sf_prod;
  logic [PROD_W-1:0]      sg_prod;

  logic                   a_valid_q;
  logic                   a_ready;
  logic [PROD_W-1:0]      a_p_q;
  logic [FRAC_BITS:0]     a_sf_q, a_sg_q, a_bright_q;
  pix_ctrl_t              a_ctrl_q;

  assign one_minus_s = ONE_Q - sat_i;
  assign one_minus_f = ONE_Q - {1'b0, frac_i};
  assign p_prod      = PROD_W'(bright_i) * PROD_W'(one_minus_s);
  assign sf_prod     = PROD_W'(sat_i) * PROD_W'(frac_i);
  assign sg_prod     = PROD_W'(sat_i) * PROD_W'(one_minus_f);

  assign ready_o = !a_valid_q || a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (ready_o) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      a_p_q      <= p_prod;
      a_sf_q     <= sf_prod[2*FRAC_BITS:FRAC_BITS];
      a_sg_q     <= sg_prod[2*FRAC_BITS:FRAC_BITS];
      a_bright_q <= bright_i;
      a_ctrl_q   <= ctrl_i;
    end
  end

  // second multiply stage
  logic [FRAC_BITS:0]     one_minus_sf, one_minus_sg;
  logic [PROD_W-1:0]      q_prod, t_prod;

  logic                   b_valid_q;
  logic [FRAC_BITS:0]     b_p_q, b_q_q, b_t_q, b_bright_q;
  pix_ctrl_t              b_ctrl_q;

  assign one_minus_sf = ONE_Q - a_sf_q;
  assign one_minus_sg = ONE_Q - a_sg_q;
  assign q_prod       = PROD_W'(a_bright_q) * PROD_W'(one_minus_sf);
  assign t_prod       = PROD_W'(a_bright_q) * PROD_W'(one_minus_sg);

  assign a_ready = !b_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && a_ready) begin
      b_p_q      <= a_p_q[2*FRAC_BITS:FRAC_BITS];
      b_q_q      <= q_prod[2*FRAC_BITS:FRAC_BITS];
      b_t_q      <= t_prod[2*FRAC_BITS:FRAC_BITS];
      b_bright_q <= a_bright_q;
      b_ctrl_q   <= a_ctrl_q;
    end
  end

  assign valid_o  = b_valid_q;
  assign bright_o = b_bright_q;
  assign p_o      = b_p_q;
  assign q_o      = b_q_q;
  assign t_o      = b_t_q;
  assign ctrl_o   = b_ctrl_q;

endmodule

/* rtl/hsv2rgb_sel.sv */
// ----------------------------------------------------------------------------
// HSV to RGB output stage
// Picks the channel terms by sector, handles black and grey, holds the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv2rgb_sel #(
  parameter int FRAC_BITS = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [FRAC_BITS:0]       bright_i,
  input  logic [FRAC_BITS:0]       p_i,
  input  logic [FRAC_BITS:0]       q_i,
  input  logic [FRAC_BITS:0]       t_i,
  input  hsv2rgb_pkg::pix_ctrl_t   ctrl_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [FRAC_BITS:0]       red_o,
  output logic [FRAC_BITS:0]       green_o,
  output logic [FRAC_BITS:0]       blue_o
);
  import hsv2rgb_pkg::*;

  localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  logic               valid_q;
  logic [FRAC_BITS:0] red_d, green_d, blue_d;
  logic [FRAC_BITS:0] red_q, green_q, blue_q;
  logic               in_fire;

  always_comb begin
    red_d   = bright_i;
    green_d = p_i;
    blue_d  = q_i;
    if (ctrl_i.black) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end else if (ctrl_i.grey) begin
      red_d   = bright_i;
      green_d = bright_i;
      blue_d  = bright_i;
    end else begin
      unique case (ctrl_i.sector)
        SEC_RED_YEL: begin
          red_d = bright_i; green_d = t_i; blue_d = p_i;
        end
        SEC_YEL_GRN: begin
          red_d = q_i; green_d = bright_i; blue_d = p_i;
        end
        SEC_GRN_CYAN: begin
          red_d = p_i; green_d = bright_i; blue_d = t_i;
        end
        SEC_CYAN_BLU: begin
          red_d = p_i; green_d = q_i; blue_d = bright_i;
        end
        SEC_BLU_MAG: begin
          red_d = t_i; green_d = p_i; blue_d = bright_i;
        end
        default: begin
          red_d = bright_i; green_d = p_i; blue_d = q_i;
        end
      endcase
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign in_fire = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

`ifndef NO_ASSERTIONS
  a_black_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && ctrl_i.black |=> red_q == '0 && green_q == '0 && blue_q == '0)
    else $error("black pixel gave nonzero color");

  a_grey_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !ctrl_i.black && ctrl_i.grey |=> red_q == green_q && green_q == blue_q)
    else $error("grey pixel gave unequal channels");

  a_max_is_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !ctrl_i.black |=> red_q == $past(bright_i) || green_q == $past(bright_i)
      || blue_q == $past(bright_i))
    else $error("no channel equals brightness");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> red_q <= ONE_Q && green_q <= ONE_Q && blue_q <= ONE_Q)
    else $error("channel above full scale");
`endif

endmodule

/* rtl/hsv_to_rgb_converter_core.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Stages: four register stages in a row: prep, two multiply ranks, select.
// Throughput: one pixel per cycle while m_axis_tready holds high.
// Reset: rst_ni clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core #(
  parameter int FRAC_BITS = 15,
  parameter int HUE_BITS  = 16,
  localparam int IN_W     = ((HUE_BITS + 2 * (FRAC_BITS + 2) + 7) / 8) * 8,
  localparam int OUT_W    = ((3 * (FRAC_BITS + 1) + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // hue_turn, sat_level, bright_level
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // red_level, green_level, blue_level
  output logic [OUT_W-1:0] m_axis_tdata
);
  import hsv2rgb_pkg::*;

  logic [HUE_BITS-1:0]  hue;
  logic [FRAC_BITS+1:0] sat_raw, bright_raw;

  assign hue        = s_axis_tdata[HUE_BITS-1:0];
  assign sat_raw    = s_axis_tdata[HUE_BITS +: FRAC_BITS+2];
  assign bright_raw = s_axis_tdata[HUE_BITS+FRAC_BITS+2 +: FRAC_BITS+2];

  logic                 pre_valid, pre_ready;
  logic [FRAC_BITS:0]   pre_sat, pre_bright;
  logic [FRAC_BITS-1:0] pre_frac;
  pix_ctrl_t            pre_ctrl;

  logic                 mul_valid, mul_ready;
  logic [FRAC_BITS:0]   mul_bright, mul_p, mul_q, mul_t;
  pix_ctrl_t            mul_ctrl;

  logic [FRAC_BITS:0]   red, green, blue;

  hsv2rgb_prep #(
    .FRAC_BITS (FRAC_BITS),
    .HUE_BITS  (HUE_BITS)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .hue_i    (hue),
    .sat_i    (sat_raw),
    .bright_i (bright_raw),
    .valid_o  (pre_valid),
    .ready_i  (pre_ready),
    .sat_o    (pre_sat),
    .bright_o (pre_bright),
    .frac_o   (pre_frac),
    .ctrl_o   (pre_ctrl)
  );

  hsv2rgb_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (pre_valid),
    .ready_o  (pre_ready),
    .sat_i    (pre_sat),
    .bright_i (pre_bright),
    .frac_i   (pre_frac),
    .ctrl_i   (pre_ctrl),
    .valid_o  (mul_valid),
    .ready_i  (mul_ready),
    .bright_o (mul_bright),
    .p_o      (mul_p),
    .q_o      (mul_q),
    .t_o      (mul_t),
    .ctrl_o   (mul_ctrl)
  );

  hsv2rgb_sel #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mul_valid),
    .ready_o  (mul_ready),
    .bright_i (mul_bright),
    .p_i      (mul_p),
    .q_i      (mul_q),
    .t_i      (mul_t),
    .ctrl_i   (mul_ctrl),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .red_o    (red),
    .green_o  (green),
    .blue_o   (blue)
  );

  assign m_axis_tdata = OUT_W'({blue, green, red});

endmodule
